/* design/nearest_rect_hit_search_macros.svh */
// Assertion macros for the nearest rectangle hit search block.
`ifndef NEAREST_RECT_HIT_SEARCH_MACROS_SVH
`define NEAREST_RECT_HIT_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// Immediate implication, checked at every clock edge out of reset.
`define NRHS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nrhs: assertion failed");

// Condition in one cycle implies a consequence in the next.
`define NRHS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nrhs: assertion failed");

`else

`define NRHS_ASSERT(name, prop)
`define NRHS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

/* design/nrhs_pkg.sv */
// Types, constants and the candidate merge rule shared by the search block.
package nrhs_pkg;

  // Widest entry index and entry count over the supported table sizes.
  localparam int IDX_MAX_W = 12;
  localparam int CNT_W     = 13;
  localparam int DIST_W    = 20;
  localparam int ADDR_W    = 3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register select is paddr[2].
  localparam logic REG_WORD_COUNT  = 1'b0;
  localparam logic REG_VERT_WEIGHT = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        entry_index;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_bottom;
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [7:0]        word_index;
    logic              exact_hit;
    logic [DIST_W-1:0] hit_distance;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] bottom;
    logic signed [15:0] right;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } rect_t;

  typedef struct packed {
    logic                 have;
    logic                 hit;
    logic [IDX_MAX_W-1:0] idx;
    logic [DIST_W-1:0]    cost;
  } cand_t;

  // Row transaction travelling along the cell chain.
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [IDX_MAX_W-1:0] row;
    cand_t                cand;
  } tok_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [3:0]         weight;
    logic [CNT_W-1:0]   n;
  } qry_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_MAX_W-1:0] row;
    rect_t                rect;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // a covers lower indices than b. First hit wins, else strictly smaller distance.
  function automatic cand_t cand_merge(cand_t a, cand_t b);
    cand_t res;
    res = a;
    priority if (!b.have) begin
      res = a;
    end else if (a.have && a.hit) begin
      res = a;
    end else if (b.hit) begin
      res = b;
    end else if (!a.have || (b.cost < a.cost)) begin
      res = b;
    end else begin
      res = a;
    end
    return res;
  endfunction

endpackage

/* design/nrhs_cell.sv */
// One search cell: a slice of the rectangle table and a three-stage compare slot.
module nrhs_cell #(
  parameter int ROWS      = 64,
  parameter int CELL_BITS = 2,
  parameter int CELL_ID   = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nrhs_pkg::wr_t  wr_i,
  input  nrhs_pkg::qry_t qry_i,
  input  nrhs_pkg::tok_t tok_i,
  output nrhs_pkg::tok_t tok_o
);
  import nrhs_pkg::*;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [CELL_BITS-1:0] ID = CELL_BITS'(CELL_ID);

  function automatic logic [15:0] axis_gap(logic signed [15:0] p, logic signed [15:0] lo,
                                           logic signed [15:0] hi);
    logic [16:0] below;
    logic [16:0] above;
    below = {lo[15], lo} - {p[15], p};
    above = {p[15], p} - {hi[15], hi};
    priority if (p < lo) begin
      return below[15:0];
    end else if (p > hi) begin
      return above[15:0];
    end else begin
      return '0;
    end
  endfunction

  rect_t mem_q [ROWS];
  rect_t rd_q;
  tok_t  s1_q, s2_q, out_q;
  tok_t  out_d;

  logic [15:0] dx_d, dy_d, dx_q, dy_q;
  logic        hit_d, ev_d, hit_q, ev_q;

  logic [ROW_W+CELL_BITS-1:0] gidx1, gidx2;
  logic [DIST_W-1:0]          wdist;
  cand_t                      own;

  // table slice: one write and one read a cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.row[ROW_W-1:0]] <= wr_i.rect;
    end
    rd_q <= mem_q[tok_i.row[ROW_W-1:0]];
  end

  // stage 1: containment and per-axis gaps
  always_comb begin
    gidx1 = {s1_q.row[ROW_W-1:0], ID};
    ev_d  = s1_q.valid && (CNT_W'(gidx1) < qry_i.n);
    hit_d = (qry_i.x >= rd_q.left) && (qry_i.x < rd_q.right) &&
            (qry_i.y >= rd_q.top) && (qry_i.y < rd_q.bottom);
    dx_d  = axis_gap(qry_i.x, rd_q.left, rd_q.right);
    dy_d  = axis_gap(qry_i.y, rd_q.top, rd_q.bottom);
  end

  // stage 2: weighted distance and merge into the passing row result
  always_comb begin
    gidx2    = {s2_q.row[ROW_W-1:0], ID};
    wdist    = DIST_W'(dx_q) + DIST_W'(dy_q) * DIST_W'(qry_i.weight);
    own.have = ev_q;
    own.hit  = hit_q;
    own.idx  = IDX_MAX_W'(gidx2);
    own.cost = hit_q ? '0 : wdist;
    out_d      = s2_q;
    out_d.cand = cand_merge(s2_q.cand, own);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      out_q <= '0;
    end else begin
      s1_q  <= tok_i;
      s2_q  <= s1_q;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    hit_q <= hit_d;
    ev_q  <= ev_d;
  end

  assign tok_o = out_q;

endmodule

/* design/nearest_rect_hit_search.sv */
// Nearest rectangle hit search: table of rectangles, first-hit or nearest query.
// A write is stored in its cell's table slice. A query with n = min(word_count, MAX_WORDS) > 0 entries
// scans ceil(n / 2**CELL_BITS) table rows, then drains the cell chain before its result is given:
// one table row enters the cell chain per cycle, each cell adds three stages; n = 0 skips the scan.
// One item is worked on at a time; the next is taken once the result is registered.
// Async reset clears control, word_count (0) and vertical_weight (4); table kept.
`include "nearest_rect_hit_search_macros.svh"

module nearest_rect_hit_search #(
  parameter int MAX_WORDS = 256,
  parameter int CELL_BITS = 2    // 1 to 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  nrhs_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output nrhs_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nrhs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import nrhs_pkg::*;

  localparam int NUM_CELLS = 1 << CELL_BITS;
  localparam int ROWS      = (MAX_WORDS + NUM_CELLS - 1) / NUM_CELLS;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

  state_e state_q, state_d;

  logic [8:0]       word_count_q;
  logic [3:0]       vweight_q;
  logic [ROW_W-1:0] ctr_q, last_row_q;
  qry_t             qry_q;
  cand_t            acc_q;
  tok_t             issue_q, issue_d;
  logic             out_valid_q;
  out_item_t        out_q;

  logic             in_acc, qry_start, wr_acc, cfg_wr, out_free, out_load;
  logic [CNT_W-1:0] n_lim, rows_needed;

  tok_t tok [NUM_CELLS+1];
  wr_t  wr  [NUM_CELLS];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_WORD_COUNT:  prdata = 32'(word_count_q);
      REG_VERT_WEIGHT: prdata = 32'(vweight_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= '0;
      vweight_q    <= 4'd4;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WORD_COUNT:  word_count_q <= pwdata[8:0];
        REG_VERT_WEIGHT: vweight_q    <= pwdata[3:0];
      endcase
    end
  end

  // input decode
  assign in_acc    = in_valid_i && !in_stall_o;
  assign qry_start = in_acc && (in_data_i.req_type == REQ_QUERY);
  assign wr_acc    = in_acc && (in_data_i.req_type == REQ_WRITE) &&
                     (32'(in_data_i.entry_index) < MAX_WORDS);

  assign n_lim       = (32'(word_count_q) > MAX_WORDS) ? CNT_W'(MAX_WORDS)
                                                       : CNT_W'(word_count_q);
  assign rows_needed = (n_lim + CNT_W'(NUM_CELLS - 1)) >> CELL_BITS;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (qry_start) begin
          state_d = (rows_needed == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ctr_q == last_row_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tok[NUM_CELLS].valid && tok[NUM_CELLS].last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    out_free   = !out_valid_q || !out_stall_i;
    out_load   = (state_q == ST_DONE) && out_free;
    issue_d    = '0;
    if (state_q == ST_SCAN) begin
      issue_d.valid = 1'b1;
      issue_d.row   = IDX_MAX_W'(ctr_q);
      issue_d.last  = (ctr_q == last_row_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= '0;
      out_valid_q <= 1'b0;
      ctr_q       <= '0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      if (qry_start) begin
        ctr_q <= '0;
      end else if (state_q == ST_SCAN) begin
        ctr_q <= ctr_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (qry_start) begin
      qry_q.x      <= in_data_i.query_x;
      qry_q.y      <= in_data_i.query_y;
      qry_q.weight <= vweight_q;
      qry_q.n      <= n_lim;
      last_row_q   <= ROW_W'(rows_needed - 1'b1);
      acc_q        <= '0;
    end else if (tok[NUM_CELLS].valid) begin
      // rows leave the chain in order, so the accumulator sees ascending indices
      acc_q <= cand_merge(acc_q, tok[NUM_CELLS].cand);
    end
    if (out_load) begin
      out_q.found        <= acc_q.have;
      out_q.word_index   <= acc_q.idx[7:0];
      out_q.exact_hit    <= acc_q.hit;
      out_q.hit_distance <= acc_q.cost;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // cell chain; entry i sits in cell i mod NUM_CELLS, row i / NUM_CELLS
  assign tok[0] = issue_q;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    always_comb begin
      wr[k].en   = wr_acc && (in_data_i.entry_index[CELL_BITS-1:0] == CELL_BITS'(k));
      wr[k].row  = IDX_MAX_W'(in_data_i.entry_index >> CELL_BITS);
      wr[k].rect.left   = in_data_i.rect_left;
      wr[k].rect.top    = in_data_i.rect_top;
      wr[k].rect.right  = in_data_i.rect_right;
      wr[k].rect.bottom = in_data_i.rect_bottom;
    end

    nrhs_cell #(
      .ROWS      (ROWS),
      .CELL_BITS (CELL_BITS),
      .CELL_ID   (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr[k]),
      .qry_i  (qry_q),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  `NRHS_ASSERT(a_tok_scan, tok[NUM_CELLS].valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
  `NRHS_ASSERT_NEXT(a_load, state_q == ST_DONE && out_free, out_valid_o && state_q == ST_IDLE)
  `NRHS_ASSERT(a_hit_zero, out_valid_q && out_q.exact_hit |-> out_q.hit_distance == '0)
  `NRHS_ASSERT(a_no_idx, out_valid_q && !out_q.found |-> out_q.word_index == '0 && !out_q.exact_hit)

endmodule

/* dv/tb.sv */
// Self-checking testbench for the nearest rectangle hit search block.
`timescale 1ns / 1ps

module tb;
  import nrhs_pkg::*;

  localparam int TABLE_DEPTH    = 256;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 105;
  localparam int MAX_REPORTS    = 20;
  localparam int ITEM_W         = $bits(in_item_t);

  // Holds a copy of the rectangle table and the registers, predicts each query.
  class hit_search_board;
    rect_t      rects[TABLE_DEPTH];
    logic [8:0] word_count;
    logic [3:0] weight;
    out_item_t  awaited[$];
    int         errors;

    function new();
      foreach (rects[i]) rects[i] = '0;
      word_count = '0;
      weight     = 4'd4;
      errors     = 0;
    endfunction

    function void set_register(logic sel, logic [31:0] value);
      if (sel == REG_WORD_COUNT) begin
        word_count = value[8:0];
      end else begin
        weight = value[3:0];
      end
    endfunction

    // Gap along one axis; an inverted span tests the low bound first.
    function int axis_gap(int p, int lo, int hi);
      if (p < lo) return lo - p;
      if (p > hi) return p - hi;
      return 0;
    endfunction

    function void note_item(in_item_t it);
      out_item_t res;
      int        n, x, y, l, t, r, b, d, best_d;
      bit        have, hit;
      if (it.req_type == REQ_WRITE) begin
        rects[it.entry_index] = {it.rect_bottom, it.rect_right, it.rect_top, it.rect_left};
        return;
      end
      res    = '0;
      have   = 1'b0;
      hit    = 1'b0;
      best_d = 0;
      n      = (word_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(word_count);
      x      = int'(it.query_x);
      y      = int'(it.query_y);
      for (int i = 0; i < n && !hit; i++) begin
        l = int'(rects[i].left);
        t = int'(rects[i].top);
        r = int'(rects[i].right);
        b = int'(rects[i].bottom);
        if (x >= l && x < r && y >= t && y < b) begin
          hit              = 1'b1;
          res.found        = 1'b1;
          res.word_index   = i[7:0];
          res.exact_hit    = 1'b1;
          res.hit_distance = '0;
        end else begin
          d = axis_gap(x, l, r) + axis_gap(y, t, b) * int'(weight);
          if (!have || d < best_d) begin
            have           = 1'b1;
            best_d         = d;
            res.found      = 1'b1;
            res.word_index = i[7:0];
          end
        end
      end
      if (!hit) res.hit_distance = best_d[DIST_W-1:0];
      awaited = {awaited, res};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with none awaited: found=%0d index=%0d exact=%0d dist=%0d",
                   $time, got.found, got.word_index, got.exact_hit, got.hit_distance);
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found || got.word_index !== want.word_index ||
          got.exact_hit !== want.exact_hit || got.hit_distance !== want.hit_distance) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: expected found=%0d index=%0d exact=%0d dist=%0d, %s%0d %s%0d %s%0d %s%0d",
                   $time, want.found, want.word_index, want.exact_hit, want.hit_distance,
                   "got found=", got.found, "index=", got.word_index,
                   "exact=", got.exact_hit, "dist=", got.hit_distance);
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  hit_search_board sb;
  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  int              quiet_cycles   = 0;

  int wc_plan[8]   = '{1, 511, 0, 64, 256, 5, 300, 17};
  int wt_plan[8]   = '{15, 0, 4, 1, 15, 9, 0, 7};
  int send_plan[4] = '{0, 48, 0, 35};
  int recv_plan[4] = '{0, 0, 48, 35};

  nearest_rect_hit_search dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Both channels observed at the edge, before any update of this step lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int corner_coord();
    case ($urandom_range(0, 3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Mostly well-formed boxes, some clustered near the origin so they overlap;
  // the rest fully random (often inverted) or pinned to the coordinate limits.
  function automatic rect_t rand_rect();
    rect_t rc;
    int    l, t, shape;
    rc    = {$urandom, $urandom};
    shape = $urandom_range(0, 9);
    if (shape == 1) begin
      rc.left   = clip16(corner_coord());
      rc.top    = clip16(corner_coord());
      rc.right  = clip16(corner_coord());
      rc.bottom = clip16(corner_coord());
    end else if (shape > 1) begin
      l = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 4000)) - 2000 : int'(rc.left);
      t = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 4000)) - 2000 : int'(rc.top);
      rc.left   = l[15:0];
      rc.top    = t[15:0];
      rc.right  = clip16(l + int'($urandom_range(0, 3000)));
      rc.bottom = clip16(t + int'($urandom_range(0, 3000)));
    end
    return rc;
  endfunction

  task automatic drive_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic put_rect(input int idx, input rect_t rc);
    in_item_t it;
    it             = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.req_type    = REQ_WRITE;
    it.entry_index = idx[7:0];
    it.rect_left   = rc.left;
    it.rect_top    = rc.top;
    it.rect_right  = rc.right;
    it.rect_bottom = rc.bottom;
    drive_item(it);
  endtask

  task automatic ask(input int x, input int y);
    in_item_t it;
    it          = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.req_type = REQ_QUERY;
    it.query_x  = clip16(x);
    it.query_y  = clip16(y);
    drive_item(it);
  endtask

  task automatic apb_write(input logic sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(sel, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending, let every query return and a trailing write retire.
  // It waits on the clock first, so the last accepted transaction is already noted.
  task automatic settle(input int extra);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic configure(input int count, input int wt);
    settle(SETTLE_CYCLES);
    apb_write(REG_WORD_COUNT, count);
    apb_write(REG_VERT_WEIGHT, wt);
  endtask

  task automatic random_item();
    rect_t rc;
    int    n, sel, x, y, sx, sy;
    n   = (sb.word_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sb.word_count);
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      put_rect($urandom_range(0, TABLE_DEPTH - 1), rand_rect());
    end else if (sel == 2) begin
      ask(corner_coord(), corner_coord());
    end else if (sel == 3 || n == 0) begin
      ask(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768);
    end else begin
      // around a live entry: inside, on its edges, or just outside
      rc = sb.rects[$urandom_range(0, n - 1)];
      sx = int'(rc.right) - int'(rc.left);
      sy = int'(rc.bottom) - int'(rc.top);
      if (sx < 0) sx = 0;
      if (sy < 0) sy = 0;
      x = int'(rc.left) + int'($urandom_range(0, sx + 6)) - 3;
      y = int'(rc.top) + int'($urandom_range(0, sy + 6)) - 3;
      ask(x, y);
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, then the largest possible distance
    ask(-32768, 32767);
    put_rect(0, {16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    configure(1, 15);
    ask(-32768, -32768);

    // overlapping boxes, an inverted box, two points at the limits, a duplicate
    put_rect(0, {16'sd50, 16'sd100, 16'sd0, 16'sd0});
    put_rect(1, {16'sd80, 16'sd200, 16'sd20, 16'sd50});
    put_rect(2, {16'sd200, 16'sd200, 16'sd300, 16'sd300});
    put_rect(3, {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    put_rect(4, {16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    put_rect(5, {16'sd600, -16'sd900, 16'sd500, -16'sd1000});
    put_rect(6, {16'sd600, -16'sd900, 16'sd500, -16'sd1000});
    configure(7, 4);
    ask(10, 10);
    ask(60, 30);
    ask(150, 30);
    ask(100, 10);
    ask(0, 0);
    ask(99, 49);
    ask(250, 250);
    ask(-32768, -32768);
    ask(32767, 32767);
    ask(-950, 400);
    configure(7, 0);
    ask(-2000, 10000);

    // populate every entry before any count can reach it
    send_idle_pct  = send_plan[3];
    recv_stall_pct = recv_plan[3];
    for (int i = 0; i < TABLE_DEPTH; i++) put_rect(i, rand_rect());

    for (int p = 0; p < 8; p++) begin
      configure(wc_plan[p], wt_plan[p]);
      send_idle_pct  = send_plan[p % 4];
      recv_stall_pct = recv_plan[p % 4];
      repeat (PHASE_ITEMS) random_item();
    end

    settle(DRAIN_CYCLES);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/nrhs_pkg.sv
design/nrhs_cell.sv
design/nearest_rect_hit_search.sv
dv/tb.sv
